// ===== rtl/bse_pkg.sv =====
// ----------------------------------------------------------------------------
// bse_pkg
// Shared types and constants for the bitmap scan engine: the operation codes,
// the field widths and the lowest-set-bit and population count helpers.
// ----------------------------------------------------------------------------
package bse_pkg;

  localparam int unsigned ModeW  = 3;
  localparam int unsigned PosW   = 12;
  localparam int unsigned WidxW  = 6;
  localparam int unsigned DataW  = 64;
  localparam int unsigned SizeW  = 13;
  localparam int unsigned ResW   = 13;
  localparam int unsigned BitIdxW = 6;

  // operation codes carried in the mode field
  localparam logic [ModeW-1:0] MODE_CLEAR = 3'd0;
  localparam logic [ModeW-1:0] MODE_OR    = 3'd1;
  localparam logic [ModeW-1:0] MODE_FIND  = 3'd2;
  localparam logic [ModeW-1:0] MODE_COUNT = 3'd3;
  localparam logic [ModeW-1:0] MODE_EMPTY = 3'd4;

  localparam logic signed [ResW-1:0] NONE_POS = -13'sd1;

  localparam logic [SizeW-1:0] SIZE_RESET = 13'd4096;

  typedef logic [DataW-1:0] word_t;

  // index of the lowest set bit, 0 when none is set
  function automatic logic [BitIdxW-1:0] low_bit_idx(input word_t w);
    logic [BitIdxW-1:0] k;
    k = '0;
    for (int i = DataW - 1; i >= 0; i--) begin
      if (w[i]) begin
        k = BitIdxW'(i);
      end
    end
    return k;
  endfunction

  // population count of one word, pairs, nibbles, then bytes folded as a tree
  function automatic logic [BitIdxW:0] pop_word(input word_t w);
    word_t x;
    x = w - ((w >> 1) & 64'h5555_5555_5555_5555);
    x = (x & 64'h3333_3333_3333_3333) + ((x >> 2) & 64'h3333_3333_3333_3333);
    x = (x + (x >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;
    x = x + (x >> 8);
    x = x + (x >> 16);
    x = x + (x >> 32);
    return x[BitIdxW:0];
  endfunction

endpackage

// ===== rtl/bitmap_scan_engine_core.sv =====
// ----------------------------------------------------------------------------
// bitmap_scan_engine_core
// Bit vector store of WORD_COUNT 64-bit words in one synchronous memory, with
// clear, or-word merge, find-next-set, population count and empty test.
// ----------------------------------------------------------------------------
// Usage
//   Items come in on the in_* channel (valid/ready) and each gives exactly one
//   result on the out_* channel (valid/ready). One item is worked on at a time.
//   cfg_we_i/cfg_wdata_i write size_in_bits at once; write it only when idle.
// Steps, with words in use = min(ceil(size/64), WORD_COUNT)
//   find-next, count, empty test: one memory read per word; find-next starts
//     at the word of the position and stops at the first word holding a hit
//   or-word: read, merge and write back, result
//   clear: all WORD_COUNT words, one word zeroed per cycle, then result
//   skipped merge, find-next past the words in use, other modes: straight to result
//   in_ready_o rises at the edge that loads the result into the output register
// Reset
//   the store is swept to zero, one word per cycle, over all WORD_COUNT words
//   after reset; in_ready_o stays low during that sweep.
// Stall
//   a result waits in the output register while out_ready_i is low and the
//   next item is still taken; its result waits until the register is free.
// ----------------------------------------------------------------------------
module bitmap_scan_engine_core #(
  parameter int unsigned WORD_COUNT = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  input  logic                                cfg_we_i,
  input  logic [bse_pkg::SizeW-1:0]           cfg_wdata_i,

  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [bse_pkg::ModeW-1:0]           mode_i,
  input  logic [bse_pkg::PosW-1:0]            position_i,
  input  logic [bse_pkg::WidxW-1:0]           word_index_i,
  input  logic [bse_pkg::DataW-1:0]           word_data_i,
  input  logic [bse_pkg::SizeW-1:0]           other_size_i,

  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [bse_pkg::ResW-1:0]     next_position_o,
  output logic [bse_pkg::ResW-1:0]            set_count_o,
  output logic                                is_empty_o
);

  localparam int unsigned IW    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int unsigned CNT_W = $clog2(WORD_COUNT + 1);
  localparam int unsigned UW    = (CNT_W > 8) ? CNT_W : 8;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CLR  = 3'd1;
  localparam logic [2:0] ST_ORR  = 3'd2;
  localparam logic [2:0] ST_ORW  = 3'd3;
  localparam logic [2:0] ST_SCAN = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]                     state_q, state_d;
  logic [bse_pkg::SizeW-1:0]      size_q;
  logic [UW-1:0]                  ptr_q, ptr_d;
  logic [UW-1:0]                  ri_q, ri_d;
  logic                           rv_q, rv_d;
  logic [UW-1:0]                  start_q, start_d;
  logic                           clr_item_q, clr_item_d;
  logic [bse_pkg::ModeW-1:0]      mode_q, mode_d;
  logic [bse_pkg::BitIdxW-1:0]    off_q, off_d;
  logic [UW-1:0]                  widx_q, widx_d;
  bse_pkg::word_t                 data_q, data_d;
  logic [bse_pkg::ResW-1:0]       cnt_q, cnt_d;
  logic                           any_q, any_d;
  logic signed [bse_pkg::ResW-1:0] res_pos_q, res_pos_d;
  logic [bse_pkg::ResW-1:0]       res_cnt_q, res_cnt_d;
  logic                           res_empty_q, res_empty_d;

  logic                           out_valid_q, out_valid_d;
  logic signed [bse_pkg::ResW-1:0] out_pos_q, out_pos_d;
  logic [bse_pkg::ResW-1:0]       out_cnt_q, out_cnt_d;
  logic                           out_empty_q, out_empty_d;

  bse_pkg::word_t                 mem_q [WORD_COUNT];
  bse_pkg::word_t                 rdata_q;
  logic [IW-1:0]                  raddr;
  logic [IW-1:0]                  waddr;
  bse_pkg::word_t                 wdata;
  logic                           mem_we;

  logic [7:0]                     used_raw;
  logic [UW-1:0]                  used;
  logic [bse_pkg::SizeW:0]        size_plus;
  logic [UW-1:0]                  in_word;
  logic [UW-1:0]                  in_widx;
  logic                           issue;
  bse_pkg::word_t                 first_mask;
  bse_pkg::word_t                 scan_word;
  logic                           hit;
  logic [UW+bse_pkg::BitIdxW-1:0] hit_pos;
  logic                           out_free;

  // words in use, capped at the store depth
  assign size_plus = {1'b0, size_q} + (bse_pkg::SizeW+1)'(63);
  assign used_raw  = size_plus[bse_pkg::SizeW:6];
  assign used      = (UW'(used_raw) > UW'(WORD_COUNT)) ? UW'(WORD_COUNT) : UW'(used_raw);

  assign in_word = UW'(position_i[bse_pkg::PosW-1:6]);
  assign in_widx = UW'(word_index_i);

  assign issue      = (ptr_q < used);
  assign first_mask = ~((bse_pkg::word_t'(2) << off_q) - bse_pkg::word_t'(1));
  assign scan_word  = (mode_q == bse_pkg::MODE_FIND && ri_q == start_q) ?
                      (rdata_q & first_mask) : rdata_q;
  assign hit        = |scan_word;
  assign hit_pos    = {ri_q, bse_pkg::low_bit_idx(scan_word)};
  assign out_free   = !out_valid_q || out_ready_i;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    ri_d        = ri_q;
    rv_d        = 1'b0;
    start_d     = start_q;
    clr_item_d  = clr_item_q;
    mode_d      = mode_q;
    off_d       = off_q;
    widx_d      = widx_q;
    data_d      = data_q;
    cnt_d       = cnt_q;
    any_d       = any_q;
    res_pos_d   = res_pos_q;
    res_cnt_d   = res_cnt_q;
    res_empty_d = res_empty_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_pos_d   = out_pos_q;
    out_cnt_d   = out_cnt_q;
    out_empty_d = out_empty_q;
    mem_we      = 1'b0;
    waddr       = ptr_q[IW-1:0];
    wdata       = '0;
    raddr       = widx_q[IW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          mode_d      = mode_i;
          off_d       = position_i[5:0];
          widx_d      = in_widx;
          data_d      = word_data_i;
          cnt_d       = '0;
          any_d       = 1'b0;
          res_pos_d   = bse_pkg::NONE_POS;
          res_cnt_d   = '0;
          res_empty_d = 1'b0;
          ptr_d       = '0;
          start_d     = '0;
          state_d     = ST_DONE;
          unique case (mode_i) inside
            bse_pkg::MODE_CLEAR: begin
              clr_item_d = 1'b1;
              state_d    = ST_CLR;
            end
            bse_pkg::MODE_OR: begin
              if (other_size_i == size_q && in_widx < used) begin
                state_d = ST_ORR;
              end
            end
            bse_pkg::MODE_FIND: begin
              if (in_word < used) begin
                ptr_d   = in_word;
                start_d = in_word;
                state_d = ST_SCAN;
              end
            end
            bse_pkg::MODE_COUNT, bse_pkg::MODE_EMPTY: begin
              state_d = ST_SCAN;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_CLR: begin
        mem_we = 1'b1;
        ptr_d  = ptr_q + UW'(1);
        if (ptr_q == UW'(WORD_COUNT - 1)) begin
          state_d = clr_item_q ? ST_DONE : ST_IDLE;
        end
      end
      ST_ORR: begin
        state_d = ST_ORW;
      end
      ST_ORW: begin
        mem_we  = 1'b1;
        waddr   = widx_q[IW-1:0];
        wdata   = rdata_q | data_q;
        state_d = ST_DONE;
      end
      ST_SCAN: begin
        raddr = ptr_q[IW-1:0];
        if (issue) begin
          ptr_d = ptr_q + UW'(1);
          ri_d  = ptr_q;
          rv_d  = 1'b1;
        end
        if (rv_q) begin
          cnt_d = cnt_q + bse_pkg::ResW'(bse_pkg::pop_word(rdata_q));
          any_d = any_q | hit;
        end
        if (rv_q && hit && mode_q == bse_pkg::MODE_FIND) begin
          res_pos_d = hit_pos[bse_pkg::ResW-1:0];
          rv_d      = 1'b0;
          state_d   = ST_DONE;
        end else if (!rv_q && !issue) begin
          if (mode_q == bse_pkg::MODE_COUNT) begin
            res_cnt_d = cnt_q;
          end
          if (mode_q == bse_pkg::MODE_EMPTY) begin
            res_empty_d = !any_q;
          end
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_pos_d   = res_pos_q;
          out_cnt_d   = res_cnt_q;
          out_empty_d = res_empty_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      ptr_q       <= '0;
      rv_q        <= 1'b0;
      clr_item_q  <= 1'b0;
      size_q      <= bse_pkg::SIZE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      rv_q        <= rv_d;
      clr_item_q  <= (state_q == ST_CLR && state_d != ST_CLR) ? 1'b0 : clr_item_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ri_q        <= ri_d;
    start_q     <= start_d;
    mode_q      <= mode_d;
    off_q       <= off_d;
    widx_q      <= widx_d;
    data_q      <= data_d;
    cnt_q       <= cnt_d;
    any_q       <= any_d;
    res_pos_q   <= res_pos_d;
    res_cnt_q   <= res_cnt_d;
    res_empty_q <= res_empty_d;
    out_pos_q   <= out_pos_d;
    out_cnt_q   <= out_cnt_d;
    out_empty_q <= out_empty_d;
  end

  // word store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  assign out_valid_o     = out_valid_q;
  assign next_position_o = out_pos_q;
  assign set_count_o     = out_cnt_q;
  assign is_empty_o      = out_empty_q;

  // a new result only comes out of the result state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_d && !(out_valid_q && !out_ready_i)) |-> state_q == ST_DONE)
    else $error("result loaded outside the result state");

  // a taken result leaves the register empty unless a new one is loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ready_i && state_q != ST_DONE) |=> !out_valid_q)
    else $error("result repeated after transfer");

  // the store is only written by the clear sweep or the merge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_CLR || state_q == ST_ORW))
    else $error("unexpected store write");

  // the scan never issues past the words in use
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (ptr_q <= used))
    else $error("scan pointer past words in use");

  // a result with a nonzero count never carries a found position or an empty flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && set_count_o != '0) |-> (next_position_o == bse_pkg::NONE_POS && !is_empty_o))
    else $error("mixed result fields");

endmodule
